@@ rtl/core/gtc_pkg.sv @@
package gtc_pkg;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_WRITE = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      REG_COUNT_LO   = 3'd0,
      REG_COUNT_HI   = 3'd1,
      REG_CONTROL    = 3'd2,
      REG_STATUS     = 3'd3,
      REG_COMPARE_LO = 3'd4,
      REG_COMPARE_HI = 3'd5,
      REG_INCREMENT  = 3'd6
   } reg_index_type;

   // bit positions in the control field
   localparam int CTRL_ENABLE  = 0;
   localparam int CTRL_COMP    = 1;
   localparam int CTRL_IRQ     = 2;
   localparam int CTRL_AUTOINC = 3;

   localparam int DATA_WIDTH = 32;
   localparam int CTRL_WIDTH = 4;
   localparam int PRE_WIDTH  = 8;

   typedef struct packed {
      cmd_type                 cmd;
      reg_index_type           reg_index;
      logic [DATA_WIDTH-1:0]   write_data;
   } req_item_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0]   read_data;
      logic                    irq;
   } rsp_item_type;

endpackage

@@ rtl/core/gtc_core.sv @@
module gtc_core #(
   parameter int COUNT_WIDTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  gtc_pkg::req_item_type item,
   output gtc_pkg::rsp_item_type result
);
   import gtc_pkg::*;

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [COUNT_WIDTH-1:0] cmp_ff, cmp_in;
   logic [DATA_WIDTH-1:0]  inc_ff, inc_in;
   logic [CTRL_WIDTH-1:0]  ctrl_ff, ctrl_in;
   logic [PRE_WIDTH-1:0]   pre_set_ff, pre_set_in;
   logic [PRE_WIDTH-1:0]   pre_cnt_ff, pre_cnt_in;
   logic                   event_ff, event_in;

   logic [COUNT_WIDTH-1:0] count_step;
   logic [COUNT_WIDTH-1:0] cmp_step;
   logic [DATA_WIDTH-1:0]  rd;

   assign count_step = count_ff + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
   assign cmp_step   = cmp_ff + {{(COUNT_WIDTH-DATA_WIDTH){1'b0}}, inc_ff};

   always_comb begin
      count_in   = count_ff;
      cmp_in     = cmp_ff;
      inc_in     = inc_ff;
      ctrl_in    = ctrl_ff;
      pre_set_in = pre_set_ff;
      pre_cnt_in = pre_cnt_ff;
      event_in   = event_ff;
      rd         = '0;
      if (item_valid) begin
         case (item.cmd)
            CMD_TICK: begin
               if (ctrl_ff[CTRL_ENABLE]) begin
                  // counter steps once the prescale count reaches the setting
                  if (pre_cnt_ff >= pre_set_ff) begin
                     pre_cnt_in = '0;
                     count_in   = count_step;
                     if (ctrl_ff[CTRL_COMP] && (count_step >= cmp_ff)) begin
                        event_in = 1'b1;
                        if (ctrl_ff[CTRL_AUTOINC]) begin
                           cmp_in = cmp_step;
                        end
                     end
                  end else begin
                     pre_cnt_in = pre_cnt_ff + {{(PRE_WIDTH-1){1'b0}}, 1'b1};
                  end
               end
            end
            CMD_READ: begin
               unique case (item.reg_index)
                  REG_COUNT_LO:   rd = count_ff[DATA_WIDTH-1:0];
                  REG_COUNT_HI:   rd = DATA_WIDTH'(count_ff >> DATA_WIDTH);
                  REG_CONTROL:    rd = {16'b0, pre_set_ff, 4'b0, ctrl_ff};
                  REG_STATUS:     rd = {{(DATA_WIDTH-1){1'b0}}, event_ff};
                  REG_COMPARE_LO: rd = cmp_ff[DATA_WIDTH-1:0];
                  REG_COMPARE_HI: rd = DATA_WIDTH'(cmp_ff >> DATA_WIDTH);
                  REG_INCREMENT:  rd = inc_ff;
                  default:        rd = '0;
               endcase
            end
            CMD_WRITE: begin
               unique case (item.reg_index)
                  REG_COUNT_LO:
                     count_in = {count_ff[COUNT_WIDTH-1:DATA_WIDTH], item.write_data};
                  REG_COUNT_HI:
                     count_in = {item.write_data[COUNT_WIDTH-DATA_WIDTH-1:0],
                                 count_ff[DATA_WIDTH-1:0]};
                  REG_CONTROL: begin
                     ctrl_in    = item.write_data[CTRL_WIDTH-1:0];
                     pre_set_in = item.write_data[15:8];
                  end
                  REG_STATUS: begin
                     // write one to clear
                     if (item.write_data[0]) begin
                        event_in = 1'b0;
                     end
                  end
                  REG_COMPARE_LO:
                     cmp_in = {cmp_ff[COUNT_WIDTH-1:DATA_WIDTH], item.write_data};
                  REG_COMPARE_HI:
                     cmp_in = {item.write_data[COUNT_WIDTH-DATA_WIDTH-1:0],
                               cmp_ff[DATA_WIDTH-1:0]};
                  REG_INCREMENT:  inc_in = item.write_data;
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   assign result.read_data = rd;
   assign result.irq       = event_in & ctrl_in[CTRL_IRQ];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         cmp_ff     <= '0;
         inc_ff     <= '0;
         ctrl_ff    <= '0;
         pre_set_ff <= '0;
         pre_cnt_ff <= '0;
         event_ff   <= 1'b0;
      end else begin
         count_ff   <= count_in;
         cmp_ff     <= cmp_in;
         inc_ff     <= inc_in;
         ctrl_ff    <= ctrl_in;
         pre_set_ff <= pre_set_in;
         pre_cnt_ff <= pre_cnt_in;
         event_ff   <= event_in;
      end
   end

endmodule

@@ rtl/core/global_timer_comparator_unit.sv @@
// channel  dir  handshake                  payload
// req      in   req_tvalid / req_tready    tuser: cmd; tdata: reg_index, write_data
// rsp      out  rsp_tvalid / rsp_tready    tdata: read_data, irq
//
// one beat per cycle sustained while rsp is not stalled; a request beat passes through
// the input register, then the timer update into the result register
// synchronous reset clears the timer state and both stages; timer comes up disabled
// a stalled rsp holds the result register; req keeps flowing while the result
// register drains in the same cycle
module global_timer_comparator_unit #(
   parameter int COUNT_WIDTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   input  logic [39:0] req_tdata,   // reg_index[2:0], write_data[34:3], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // read_data[31:0], irq[32], zero pad
);
   import gtc_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff, in_item_in;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;
   rsp_item_type core_result;
   logic         advance;
   logic         req_fire;

   assign advance    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;
   assign req_fire   = req_tvalid & req_tready;

   always_comb begin
      in_item_in.cmd        = cmd_type'(req_tuser);
      in_item_in.reg_index  = reg_index_type'(req_tdata[2:0]);
      in_item_in.write_data = req_tdata[34:3];
      in_valid_in = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
      out_item_in  = advance ? core_result : out_item_ff;
   end

   gtc_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (advance),
      .item       (in_item_ff),
      .result     (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= in_item_in;
      end
      out_item_ff <= out_item_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0, out_item_ff.irq, out_item_ff.read_data};

endmodule
